// ===== rtl/core/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants of the circular double-ended queue.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

  localparam int unsigned CAP_W  = 11;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned MODE_W = 3;

  localparam int unsigned CAP_RESET = 1024;

  localparam logic [DATA_W-1:0] EMPTY_WORD = {DATA_W{1'b1}};

  typedef enum logic [MODE_W-1:0] {
    MODE_INS_FRONT = 3'd0,
    MODE_INS_REAR  = 3'd1,
    MODE_DEL_FRONT = 3'd2,
    MODE_DEL_REAR  = 3'd3,
    MODE_NONE      = 3'd4
  } mode_t;

  typedef struct packed {
    logic ok;
    logic is_empty;
    logic is_full;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/circular_deque.sv =====
// ----------------------------------------------------------------------------
// circular_deque
// Path: start is registered into in_valid_r (step stage), then out_valid_r drives out_strobe.
// Throughput: one item every cycle; busy stays low, the receiver cannot stall.
// Pointer step and store write happen in the step stage; the two-port store read lands in the output stage.
// Reset: capacity 1024 (at most DEPTH), deque empty; store contents undefined.
// A capacity write empties the deque in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_deque #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [cdq_pkg::CAP_W-1:0]   cfg_wdata,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [cdq_pkg::MODE_W-1:0]  in_mode,
  input  wire logic [cdq_pkg::DATA_W-1:0]  in_value,
  output logic                             out_strobe,
  output logic                             out_ok,
  output logic      [cdq_pkg::DATA_W-1:0]  out_front_value,
  output logic      [cdq_pkg::DATA_W-1:0]  out_rear_value,
  output logic                             out_is_empty,
  output logic                             out_is_full
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned DW = cdq_pkg::DATA_W;

  logic                         in_valid_r;
  logic [cdq_pkg::MODE_W-1:0]   in_mode_r;
  logic [DW-1:0]                in_value_r;

  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  logic [AW-1:0]                rd_addr_f;
  logic [AW-1:0]                rd_addr_r;
  cdq_pkg::status_t             status;

  logic [DW-1:0]                q_f;
  logic [DW-1:0]                q_r;

  logic                         out_valid_r;
  cdq_pkg::status_t             status_r;
  logic                         hit_f_r;
  logic                         hit_r_r;
  logic [DW-1:0]                wdata_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_mode_r  <= in_mode;
      in_value_r <= in_value;
    end
  end

  cdq_ptr #(
    .DEPTH(DEPTH)
  ) u_ptr (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step_valid(in_valid_r),
    .step_mode (in_mode_r),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .rd_addr_f (rd_addr_f),
    .rd_addr_r (rd_addr_r),
    .status    (status)
  );

  cdq_ram #(
    .WIDTH(DW),
    .DEPTH(DEPTH)
  ) u_slots (
    .clk    (clk),
    .we     (wr_en),
    .waddr  (wr_addr),
    .wdata  (in_value_r),
    .raddr_a(rd_addr_f),
    .rdata_a(q_f),
    .raddr_b(rd_addr_r),
    .rdata_b(q_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status;
    hit_f_r  <= wr_en && (rd_addr_f == wr_addr);
    hit_r_r  <= wr_en && (rd_addr_r == wr_addr);
    wdata_r  <= in_value_r;
  end

  assign out_strobe      = out_valid_r;
  assign out_ok          = status_r.ok;
  assign out_is_empty    = status_r.is_empty;
  assign out_is_full     = status_r.is_full;
  assign out_front_value = status_r.is_empty ? cdq_pkg::EMPTY_WORD :
                           (hit_f_r ? wdata_r : q_f);
  assign out_rear_value  = status_r.is_empty ? cdq_pkg::EMPTY_WORD :
                           (hit_r_r ? wdata_r : q_r);

`ifndef SYNTHESIS
  a_wr_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> in_valid_r)
    else $error("store written without an item in the step stage");

  a_wr_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> status.ok)
    else $error("refused operation wrote the store");

  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r |=> out_strobe)
    else $error("item in step stage gave no result strobe");

  a_not_empty_and_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_is_empty && out_is_full))
    else $error("result reports empty and full at once");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/cdq_ram.sv =====
// ----------------------------------------------------------------------------
// cdq_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr_a,
  output logic      [WIDTH-1:0] rdata_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ===== rtl/core/cdq_ptr.sv =====
// ----------------------------------------------------------------------------
// cdq_ptr
// Capacity, front and rear pointers and entry count; one step per cycle,
// giving the store write and the read addresses of the new front and rear.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ptr #(
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [cdq_pkg::CAP_W-1:0] cfg_wdata,
  input  wire logic                      step_valid,
  input  wire logic [cdq_pkg::MODE_W-1:0] step_mode,
  output logic                           wr_en,
  output logic      [AW-1:0]             wr_addr,
  output logic      [AW-1:0]             rd_addr_f,
  output logic      [AW-1:0]             rd_addr_r,
  output cdq_pkg::status_t               status
);

  localparam int unsigned CW      = cdq_pkg::CAP_W;
  localparam int unsigned XW      = ((AW > CW) ? AW : CW) + 1;
  localparam int unsigned CAP_MAX = (DEPTH < 2047) ? DEPTH : 2047;
  localparam int unsigned CAP_RST = (cdq_pkg::CAP_RESET < CAP_MAX) ?
                                    cdq_pkg::CAP_RESET : CAP_MAX;

  logic [CW-1:0] cap_r, cap_nxt;
  logic [AW-1:0] ff_r, ff_nxt;
  logic [AW-1:0] rf_r, rf_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] cap_new;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] x,
                                              input logic [CW-1:0] cap);
    logic [XW-1:0] xe;
    xe = XW'(x) + XW'(1);
    return (xe >= XW'(cap)) ? '0 : AW'(xe);
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] x,
                                              input logic [CW-1:0] cap);
    logic [XW-1:0] ce;
    ce = XW'(cap) - XW'(1);
    return (x == '0) ? AW'(ce) : (x - AW'(1));
  endfunction

  function automatic logic [CW-1:0] clamp_cap(input logic [CW-1:0] v);
    logic [CW-1:0] r;
    r = v;
    if (v == '0) begin
      r = CW'(1);
    end else if (XW'(v) > XW'(CAP_MAX)) begin
      r = CW'(CAP_MAX);
    end
    return r;
  endfunction

  assign cap_new = clamp_cap(cfg_wdata);

  always_comb begin
    cap_nxt   = cap_r;
    ff_nxt    = ff_r;
    rf_nxt    = rf_r;
    cnt_nxt   = cnt_r;
    wr_en     = 1'b0;
    wr_addr   = ff_r;
    status.ok = 1'b1;
    if (cfg_we) begin
      cap_nxt = cap_new;
      ff_nxt  = '0;
      rf_nxt  = AW'(cap_new - CW'(1));
      cnt_nxt = '0;
    end else if (step_valid) begin
      unique case (cdq_pkg::mode_t'(step_mode))
        cdq_pkg::MODE_INS_FRONT: begin
          if (cnt_r >= cap_r) begin
            status.ok = 1'b0;
          end else begin
            wr_en   = 1'b1;
            wr_addr = ff_r;
            ff_nxt  = wrap_inc(ff_r, cap_r);
            cnt_nxt = cnt_r + CW'(1);
          end
        end
        cdq_pkg::MODE_INS_REAR: begin
          if (cnt_r >= cap_r) begin
            status.ok = 1'b0;
          end else begin
            wr_en   = 1'b1;
            wr_addr = rf_r;
            rf_nxt  = wrap_dec(rf_r, cap_r);
            cnt_nxt = cnt_r + CW'(1);
          end
        end
        cdq_pkg::MODE_DEL_FRONT: begin
          if (cnt_r == '0) begin
            status.ok = 1'b0;
          end else begin
            ff_nxt  = wrap_dec(ff_r, cap_r);
            cnt_nxt = cnt_r - CW'(1);
          end
        end
        cdq_pkg::MODE_DEL_REAR: begin
          if (cnt_r == '0) begin
            status.ok = 1'b0;
          end else begin
            rf_nxt  = wrap_inc(rf_r, cap_r);
            cnt_nxt = cnt_r - CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
    rd_addr_f       = wrap_dec(ff_nxt, cap_r);
    rd_addr_r       = wrap_inc(rf_nxt, cap_r);
    status.is_empty = (cnt_nxt == '0);
    status.is_full  = (cnt_nxt == cap_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CW'(CAP_RST);
      ff_r  <= '0;
      rf_r  <= AW'(CAP_RST - 1);
      cnt_r <= '0;
    end else begin
      cap_r <= cap_nxt;
      ff_r  <= ff_nxt;
      rf_r  <= rf_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire
